[sv/dvrc_pkg.sv]
// Shared types, constants and helpers for the distance-vector route coordinator.
`default_nettype none
package dvrc_pkg;

    localparam int NUM_DEST   = 128;
    localparam int DEST_W     = $clog2(NUM_DEST);
    localparam int MAX_NB     = 16;
    localparam int NB_W       = $clog2(MAX_NB);
    localparam int SUCC_W     = $clog2(MAX_NB + 1);
    localparam int NBCNT_W    = 5;
    localparam int DIST_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIST_W-1:0] INF_DIST = DIST_W'((1 << DIST_W) - 1);
    localparam logic [SUCC_W-1:0] NB_NONE  = SUCC_W'(MAX_NB);

    // Incoming message kinds
    localparam logic [KIND_W-1:0] REQ_ROUTE   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_COORD   = 2'd1;
    localparam logic [KIND_W-1:0] REQ_UNCOORD = 2'd2;

    // Outgoing message kinds
    localparam logic [KIND_W-1:0] MSG_ROUTE   = 2'd0;
    localparam logic [KIND_W-1:0] MSG_COORD   = 2'd1;
    localparam logic [KIND_W-1:0] MSG_UNCOORD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NB_COUNT = 1'd1;

    typedef struct packed {
        logic [DIST_W-1:0] hops;
        logic [SUCC_W-1:0] succ;
        logic              coord;
        logic [SUCC_W-1:0] held;
        logic [MAX_NB-1:0] pend;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        hops:  INF_DIST,
        succ:  NB_NONE,
        coord: 1'b0,
        held:  NB_NONE,
        pend:  '0
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              to_all;
        logic [NB_W-1:0]   target;
        logic [DEST_W-1:0] dest;
        logic [DIST_W-1:0] hops;
        logic              last;
    } t_msg;

    // Up to two results from one message, slot 0 first
    typedef struct packed {
        logic v0;
        t_msg m0;
        logic v1;
        t_msg m1;
    } t_push;

    typedef struct packed {
        logic              rd_en;
        logic [DEST_W-1:0] rd_addr;
        logic              wr_en;
        logic [DEST_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_tab_req;

    function automatic t_msg mk_msg(input logic [KIND_W-1:0] kind,
                                    input logic              to_all,
                                    input logic [NB_W-1:0]   target,
                                    input logic [DEST_W-1:0] dest,
                                    input logic [DIST_W-1:0] hops);
        t_msg m;
        m.kind   = kind;
        m.to_all = to_all;
        m.target = to_all ? '0 : target;
        m.dest   = dest;
        m.hops   = (kind == MSG_ROUTE) ? hops : '0;
        m.last   = 1'b0;
        return m;
    endfunction

endpackage
`default_nettype wire

[sv/dvrc_req_if.sv]
// Channel carrying incoming control messages.
`default_nettype none
interface dvrc_req_if import dvrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [NB_W-1:0]   from_neighbor;
    logic [DEST_W-1:0] dest;
    logic [DIST_W-1:0] advertised_dist;

    modport source(output valid, output req_type, output from_neighbor, output dest,
                   output advertised_dist, input ready);
    modport sink(input valid, input req_type, input from_neighbor, input dest,
                 input advertised_dist, output ready);
endinterface
`default_nettype wire

[sv/dvrc_msg_if.sv]
// Channel carrying outgoing control messages.
`default_nettype none
interface dvrc_msg_if import dvrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] msg_kind;
    logic              to_all;
    logic [NB_W-1:0]   target_neighbor;
    logic [DEST_W-1:0] dest_out;
    logic [DIST_W-1:0] dist_out;
    logic              last;

    modport source(output valid, output msg_kind, output to_all, output target_neighbor,
                   output dest_out, output dist_out, output last, input ready);
    modport sink(input valid, input msg_kind, input to_all, input target_neighbor,
                 input dest_out, input dist_out, input last, output ready);
endinterface
`default_nettype wire

[sv/dvrc_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module dvrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[sv/dvrc_engine.sv]
// Message decode, table read-modify-write and result generation.
`default_nettype none
module dvrc_engine import dvrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_room,
    input  t_entry                i_rd_data,
    dvrc_req_if.sink              i_req,
    output t_tab_req              o_tab,
    output t_push                 o_push
);
    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state              r_state;
    logic [KIND_W-1:0]   r_req_type;
    logic [NB_W-1:0]     r_from;
    logic [DEST_W-1:0]   r_dest;
    logic [DIST_W-1:0]   r_adv;
    logic [DEST_W-1:0]   r_node_id;
    logic [NBCNT_W-1:0]  r_nb_cnt;
    logic [NUM_DEST-1:0] r_tab_vld;
    logic                r_hit;

    logic                accept;
    t_entry              e;
    t_entry              n_e;
    logic                wr;
    logic                own;
    logic [DIST_W-1:0]   eff_dist;
    logic [SUCC_W-1:0]   eff_succ;
    logic [NBCNT_W-1:0]  lc;
    logic [MAX_NB-1:0]   lmask;
    logic [MAX_NB-1:0]   pend_left;
    logic [DIST_W-1:0]   nd;
    logic                a_v;
    logic                b_v;
    t_msg                a_m;
    t_msg                b_m;

    assign i_req.ready = (r_state == S_IDLE) && i_room;
    assign accept      = i_req.valid && i_req.ready;

    // Entries never written read as their reset value
    assign e        = r_hit ? i_rd_data : ENTRY_RESET;
    assign own      = (r_dest == r_node_id);
    assign eff_dist = own ? '0 : e.hops;
    assign eff_succ = own ? NB_NONE : e.succ;
    assign lc       = (r_nb_cnt > NBCNT_W'(MAX_NB)) ? NBCNT_W'(MAX_NB) : r_nb_cnt;
    assign nd       = r_adv + DIST_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_NB; i++) begin
            lmask[i] = (NBCNT_W'(i) < lc);
        end
    end

    assign pend_left = e.pend & ~(MAX_NB'(1) << r_from);

    always_comb begin
        n_e = e;
        wr  = 1'b0;
        a_v = 1'b0;
        b_v = 1'b0;
        a_m = mk_msg(MSG_ROUTE, 1'b1, '0, r_dest, '0);
        b_m = mk_msg(MSG_UNCOORD, 1'b0, r_from, r_dest, '0);
        case (r_req_type)
            REQ_ROUTE: begin
                if (!own && r_adv < INF_DIST - DIST_W'(1)) begin
                    if (e.hops == INF_DIST || nd < e.hops) begin
                        wr       = 1'b1;
                        n_e.hops = nd;
                        n_e.succ = {1'b0, r_from};
                        a_v      = !e.coord;
                        a_m      = mk_msg(MSG_ROUTE, 1'b1, '0, r_dest, nd);
                    end
                end
            end
            REQ_COORD: begin
                if (e.coord) begin
                    b_v = 1'b1;
                end else if ({1'b0, r_from} != eff_succ) begin
                    a_v = (eff_dist != INF_DIST);
                    a_m = mk_msg(MSG_ROUTE, 1'b0, r_from, r_dest, eff_dist);
                    b_v = 1'b1;
                end else begin
                    wr        = 1'b1;
                    n_e.coord = 1'b1;
                    n_e.held  = e.succ;
                    n_e.hops  = INF_DIST;
                    n_e.succ  = NB_NONE;
                    n_e.pend  = lmask;
                    a_v       = 1'b1;
                    a_m       = mk_msg(MSG_COORD, 1'b1, '0, r_dest, '0);
                end
            end
            REQ_UNCOORD: begin
                if (e.coord) begin
                    wr       = 1'b1;
                    n_e.pend = pend_left;
                    if ((pend_left & lmask) == '0) begin
                        // Last reply in: leave coordination
                        n_e.coord = 1'b0;
                        a_v = (eff_dist != INF_DIST);
                        a_m = mk_msg(MSG_ROUTE, 1'b1, '0, r_dest, eff_dist);
                        b_v = (e.held != NB_NONE) && (e.held < lc);
                        b_m = mk_msg(MSG_UNCOORD, 1'b0, e.held[NB_W-1:0], r_dest, '0);
                    end
                end
            end
            default: begin
                // unknown kind: drop
            end
        endcase
    end

    // Compact into slot 0 first and flag the final result
    always_comb begin
        o_push    = '0;
        o_push.v0 = (r_state == S_EXEC) && (a_v || b_v);
        o_push.m0 = a_v ? a_m : b_m;
        o_push.m0.last = !(a_v && b_v);
        o_push.v1 = (r_state == S_EXEC) && a_v && b_v;
        o_push.m1 = b_m;
        o_push.m1.last = 1'b1;
    end

    always_comb begin
        o_tab.rd_en   = accept;
        o_tab.rd_addr = i_req.dest;
        o_tab.wr_en   = (r_state == S_EXEC) && wr;
        o_tab.wr_addr = r_dest;
        o_tab.wr_data = n_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_node_id <= '0;
            r_nb_cnt  <= '0;
            r_tab_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_ID:  r_node_id <= i_cfg_data[DEST_W-1:0];
                    CFG_NB_COUNT: r_nb_cnt  <= i_cfg_data[NBCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_tab.wr_en) begin
                        r_tab_vld[r_dest] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_from     <= i_req.from_neighbor;
            r_dest     <= i_req.dest;
            r_adv      <= i_req.advertised_dist;
            r_hit      <= r_tab_vld[i_req.dest];
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted message not followed by table update");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.v0 && !o_push.m0.last))
        else $error("second result without a non-final first result");

    a_own_route_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_req_type == REQ_ROUTE && r_dest == r_node_id)
            |-> !o_tab.wr_en)
        else $error("route advert wrote own node entry");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tab.wr_en || o_push.v0) |-> (r_state == S_EXEC))
        else $error("table write or result outside update cycle");
endmodule
`default_nettype wire

[sv/dvrc_ofifo.sv]
// Result queue: takes up to two results a cycle, hands out one per transfer.
`default_nettype none
module dvrc_ofifo import dvrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    dvrc_msg_if.source  o_msg
);
    t_msg                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_CW-1:0]  r_count;

    logic                pop;
    logic [FIFO_CW-1:0]  n_count;
    logic [FIFO_AW-1:0]  wp1;
    t_msg                head;

    assign pop  = o_msg.valid && o_msg.ready;
    assign wp1  = r_wp + FIFO_AW'(1);
    assign head = r_mem[r_rp];

    // Room for the worst case of two results from the next message
    assign o_room = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    assign n_count = r_count + FIFO_CW'(i_push.v0) + FIFO_CW'(i_push.v1) - FIFO_CW'(pop);

    assign o_msg.valid           = (r_count != '0);
    assign o_msg.msg_kind        = head.kind;
    assign o_msg.to_all          = head.to_all;
    assign o_msg.target_neighbor = head.target;
    assign o_msg.dest_out        = head.dest;
    assign o_msg.dist_out        = head.hops;
    assign o_msg.last            = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.v0) begin
                r_wp <= i_push.v1 ? wp1 + FIFO_AW'(1) : wp1;
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.m0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_push.m1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= FIFO_CW'(FIFO_DEPTH - 2)))
        else $error("result pushed without room for two");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.v0 && !pop) |=> $stable(r_count))
        else $error("result queue count moved without push or pop");
endmodule
`default_nettype wire

[sv/distance_vector_route_coordinator_unit.sv]
// Top level of the distance-vector route coordinator.
// Handles one control message at a time: its destination's table entry is
// read in the cycle the message transfers, then modified and written back
// in the next; no new message is taken until this single read-then-write
// pass over the 128-entry route table is done. Each message gives zero to
// two result messages, queued four deep and handed out one per output
// transfer; a new message is taken only while at least two queue slots are
// free, so a slow output side throttles the input. Entries never written
// read as unknown (infinite distance, no successor, not coordinating) from
// per-entry valid bits cleared at reset, so no clearing pass is needed.
// The user must write configuration (node_id at index 0, neighbor_count
// at index 1) only while no message is in flight; this is not enforced.
`default_nettype none
module distance_vector_route_coordinator_unit import dvrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dvrc_req_if.sink              i_req,
    dvrc_msg_if.source            o_msg
);
    t_tab_req             tab;
    t_push                push;
    logic                 room;
    logic [ENTRY_W-1:0]   rd_raw;

    dvrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_DEST)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab.wr_en),
        .i_waddr (tab.wr_addr),
        .i_wdata (tab.wr_data),
        .i_re    (tab.rd_en),
        .i_raddr (tab.rd_addr),
        .o_rdata (rd_raw)
    );

    dvrc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_room     (room),
        .i_rd_data  (t_entry'(rd_raw)),
        .i_req      (i_req),
        .o_tab      (tab),
        .o_push     (push)
    );

    dvrc_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_msg   (o_msg)
    );
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the distance-vector route coordinator unit.
module tb;
    import dvrc_pkg::*;

    localparam logic [KIND_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS   = 200;
    localparam int NUM_SEGS    = 6;

    class route_scoreboard;
        logic [DIST_W-1:0]  dist_tab [NUM_DEST];
        logic [SUCC_W-1:0]  succ_tab [NUM_DEST];
        bit                 coord_tab[NUM_DEST];
        logic [SUCC_W-1:0]  held_tab [NUM_DEST];
        logic [MAX_NB-1:0]  pend_tab [NUM_DEST];
        logic [DEST_W-1:0]  node_id;
        logic [NBCNT_W-1:0] link_cnt;
        t_msg               outgoing_q[$];
        int                 errors;
        int                 checked;

        function new();
            for (int i = 0; i < NUM_DEST; i++) begin
                dist_tab[i]  = INF_DIST;
                succ_tab[i]  = NB_NONE;
                coord_tab[i] = 1'b0;
                held_tab[i]  = NB_NONE;
                pend_tab[i]  = '0;
            end
            node_id  = '0;
            link_cnt = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int linked();
            return (link_cnt > MAX_NB) ? MAX_NB : int'(link_cnt);
        endfunction

        function logic [MAX_NB-1:0] linked_mask();
            logic [MAX_NB:0] m;
            m = (17'd1 << linked()) - 17'd1;
            return m[MAX_NB-1:0];
        endfunction

        function logic [DIST_W-1:0] own_dist(logic [DEST_W-1:0] d);
            return (d == node_id) ? '0 : dist_tab[d];
        endfunction

        function logic [SUCC_W-1:0] own_succ(logic [DEST_W-1:0] d);
            return (d == node_id) ? NB_NONE : succ_tab[d];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NODE_ID)
                node_id = data;
            else
                link_cnt = data[NBCNT_W-1:0];
        endfunction

        function t_msg make_msg(logic [KIND_W-1:0] kind, logic to_all, logic [NB_W-1:0] target,
                                logic [DEST_W-1:0] d, logic [DIST_W-1:0] hops);
            t_msg m;
            m.kind   = kind;
            m.to_all = to_all;
            m.target = to_all ? '0 : target;
            m.dest   = d;
            m.hops   = (kind == MSG_ROUTE) ? hops : '0;
            m.last   = 1'b0;
            return m;
        endfunction

        // Work out the messages that one accepted request gives, and update the table
        function void note_request(logic [KIND_W-1:0] rt, logic [NB_W-1:0] fn,
                                   logic [DEST_W-1:0] d, logic [DIST_W-1:0] adv);
            t_msg              res[2];
            int                n;
            logic [DIST_W-1:0] dd;
            logic [SUCC_W-1:0] hs;
            n = 0;
            if (rt == REQ_ROUTE) begin
                if (d != node_id && adv < INF_DIST - 1) begin
                    dd = adv + 1'b1;
                    if (dist_tab[d] == INF_DIST || dd < dist_tab[d]) begin
                        dist_tab[d] = dd;
                        succ_tab[d] = {1'b0, fn};
                        if (!coord_tab[d]) begin
                            res[n] = make_msg(MSG_ROUTE, 1'b1, '0, d, dd);
                            n++;
                        end
                    end
                end
            end else if (rt == REQ_COORD) begin
                if (coord_tab[d]) begin
                    res[n] = make_msg(MSG_UNCOORD, 1'b0, fn, d, '0);
                    n++;
                end else if ({1'b0, fn} != own_succ(d)) begin
                    dd = own_dist(d);
                    if (dd != INF_DIST) begin
                        res[n] = make_msg(MSG_ROUTE, 1'b0, fn, d, dd);
                        n++;
                    end
                    res[n] = make_msg(MSG_UNCOORD, 1'b0, fn, d, '0);
                    n++;
                end else begin
                    coord_tab[d] = 1'b1;
                    held_tab[d]  = succ_tab[d];
                    dist_tab[d]  = INF_DIST;
                    succ_tab[d]  = NB_NONE;
                    pend_tab[d]  = linked_mask();
                    res[n] = make_msg(MSG_COORD, 1'b1, '0, d, '0);
                    n++;
                end
            end else if (rt == REQ_UNCOORD) begin
                if (coord_tab[d]) begin
                    pend_tab[d] &= ~(16'd1 << fn);
                    if ((pend_tab[d] & linked_mask()) == '0) begin
                        dd = own_dist(d);
                        hs = held_tab[d];
                        coord_tab[d] = 1'b0;
                        if (dd != INF_DIST) begin
                            res[n] = make_msg(MSG_ROUTE, 1'b1, '0, d, dd);
                            n++;
                        end
                        if (hs != NB_NONE && hs < linked()) begin
                            res[n] = make_msg(MSG_UNCOORD, 1'b0, hs[NB_W-1:0], d, '0);
                            n++;
                        end
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                if (i == n - 1)
                    res[i].last = 1'b1;
                outgoing_q.push_back(res[i]);
            end
        endfunction

        task report(string what, int got_v, int want_v);
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
            errors++;
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic to_all, logic [NB_W-1:0] target,
                          logic [DEST_W-1:0] d, logic [DIST_W-1:0] hops, logic last);
            t_msg want;
            checked++;
            if (outgoing_q.size() == 0) begin
                report("unexpected transfer, dest_out", d, -1);
            end else begin
                want = outgoing_q.pop_front();
                if (kind !== want.kind)     report("msg_kind", kind, want.kind);
                if (to_all !== want.to_all) report("to_all", to_all, want.to_all);
                if (target !== want.target) report("target_neighbor", target, want.target);
                if (d !== want.dest)        report("dest_out", d, want.dest);
                if (hops !== want.hops)     report("dist_out", hops, want.hops);
                if (last !== want.last)     report("last", last, want.last);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dvrc_req_if req_if ();
    dvrc_msg_if msg_if ();

    distance_vector_route_coordinator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_msg      (msg_if)
    );

    route_scoreboard sb = new();

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;
    int n_requests   = 0;
    int stall_cycles = 0;
    logic [DEST_W-1:0] dest_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus one long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        msg_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                msg_if.ready = 1'b0;
                hold_left--;
            end else begin
                msg_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && msg_if.valid && msg_if.ready)
            sb.check_result(msg_if.msg_kind, msg_if.to_all, msg_if.target_neighbor,
                            msg_if.dest_out, msg_if.dist_out, msg_if.last);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (msg_if.valid && msg_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", stall_cycles);
            $display("distance_vector_route_coordinator_unit: mismatch");
            $finish;
        end
    end

    task automatic offer_request(input logic [KIND_W-1:0] rt, input logic [NB_W-1:0] fn,
                                 input logic [DEST_W-1:0] d, input logic [DIST_W-1:0] adv);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid           = 1'b1;
        req_if.req_type        = rt;
        req_if.from_neighbor   = fn;
        req_if.dest            = d;
        req_if.advertised_dist = adv;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(rt, fn, d, adv);
        n_requests++;
    endtask

    // Drop valid and let the block drain before touching the registers
    task automatic settle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.outgoing_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [NB_W-1:0] pick_sender();
        int lc;
        lc = sb.linked();
        if (lc == 0 || $urandom_range(0, 99) < 20)
            return NB_W'($urandom_range(0, MAX_NB - 1));
        return NB_W'($urandom_range(0, lc - 1));
    endfunction

    function automatic logic [DEST_W-1:0] pick_dest();
        if ($urandom_range(0, 99) < 15)
            return DEST_W'($urandom_range(0, NUM_DEST - 1));
        return dest_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [DIST_W-1:0] pick_adv();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return DIST_W'($urandom_range(250, 255));
        if (r < 15)
            return DIST_W'($urandom_range(0, 255));
        return DIST_W'($urandom_range(0, 12));
    endfunction

    task automatic random_request();
        logic [KIND_W-1:0] rt;
        if ($urandom_range(0, 99) < 4) begin
            rt = REQ_UNKNOWN;
        end else begin
            case ($urandom_range(0, 2))
                0:       rt = REQ_ROUTE;
                1:       rt = REQ_COORD;
                default: rt = REQ_UNCOORD;
            endcase
        end
        offer_request(rt, pick_sender(), pick_dest(), pick_adv());
    endtask

    // Install a route, coordinate from its successor, then collect the replies
    task automatic coord_round();
        int                order[MAX_NB];
        int                lc;
        int                k;
        int                tmp;
        logic [DEST_W-1:0] d;
        logic [NB_W-1:0]   s;
        d = pick_dest();
        s = pick_sender();
        if (sb.succ_tab[d] == NB_NONE || $urandom_range(0, 99) < 30)
            offer_request(REQ_ROUTE, s, d, DIST_W'($urandom_range(0, 12)));
        if (sb.succ_tab[d] != NB_NONE && $urandom_range(0, 99) < 85)
            s = sb.succ_tab[d][NB_W-1:0];
        offer_request(REQ_COORD, s, d, DIST_W'($urandom_range(0, 255)));
        lc = sb.linked();
        for (int j = 0; j < lc; j++)
            order[j] = j;
        for (int j = lc - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        for (int j = 0; j < lc; j++) begin
            if ($urandom_range(0, 99) < 10)
                random_request();
            if ($urandom_range(0, 99) >= 8)
                offer_request(REQ_UNCOORD, NB_W'(order[j]), d, DIST_W'($urandom_range(0, 255)));
        end
        if (lc == 0)
            offer_request(REQ_UNCOORD, pick_sender(), d, DIST_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int seg_node[NUM_SEGS];
        int seg_nb[NUM_SEGS];
        int start;
        seg_node = '{0, 127, 64, 1, 85, 42};
        seg_nb   = '{16, 3, 0, 31, 1, 8};

        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = CFG_NODE_ID;
        cfg_data               = '0;
        req_if.valid           = 1'b0;
        req_if.req_type        = REQ_ROUTE;
        req_if.from_neighbor   = '0;
        req_if.dest            = '0;
        req_if.advertised_dist = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        snd_idle_pct = 35;
        rcv_idle_pct = 63;
        write_reg(CFG_NODE_ID, 7'd5);
        write_reg(CFG_NB_COUNT, 7'd4);

        // Directed: adverts, own entry, limits, two full coordination rounds
        offer_request(REQ_ROUTE,   4'd1,  7'd10,  8'd3);
        offer_request(REQ_ROUTE,   4'd2,  7'd10,  8'd5);
        offer_request(REQ_ROUTE,   4'd2,  7'd10,  8'd0);
        offer_request(REQ_ROUTE,   4'd0,  7'd20,  8'd253);
        offer_request(REQ_ROUTE,   4'd0,  7'd21,  8'd254);
        offer_request(REQ_ROUTE,   4'd0,  7'd22,  8'd255);
        offer_request(REQ_ROUTE,   4'd3,  7'd5,   8'd0);
        offer_request(REQ_UNKNOWN, 4'd1,  7'd10,  8'd0);
        offer_request(REQ_COORD,   4'd0,  7'd10,  8'd0);
        offer_request(REQ_COORD,   4'd3,  7'd30,  8'd0);
        offer_request(REQ_COORD,   4'd1,  7'd5,   8'd0);
        offer_request(REQ_COORD,   4'd2,  7'd10,  8'd0);
        offer_request(REQ_COORD,   4'd1,  7'd10,  8'd0);
        offer_request(REQ_ROUTE,   4'd3,  7'd10,  8'd7);
        for (int j = 0; j < 4; j++)
            offer_request(REQ_UNCOORD, NB_W'(j), 7'd10, 8'd0);
        offer_request(REQ_UNCOORD, 4'd0,  7'd40,  8'd0);
        offer_request(REQ_ROUTE,   4'd15, 7'd127, 8'd0);
        offer_request(REQ_COORD,   4'd15, 7'd127, 8'd0);
        for (int j = 0; j < 4; j++)
            offer_request(REQ_UNCOORD, NB_W'(j), 7'd127, 8'd0);
        offer_request(REQ_ROUTE,   4'd0,  7'd0,   8'd1);
        settle();

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            if (seg < 2) begin
                snd_idle_pct = 35;
                rcv_idle_pct = 63;
            end else if (seg < 4) begin
                snd_idle_pct = 63;
                rcv_idle_pct = 35;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_reg(CFG_NODE_ID, CFG_DATA_W'(seg_node[seg]));
            write_reg(CFG_NB_COUNT, CFG_DATA_W'(seg_nb[seg]));
            dest_pool[0] = DEST_W'(seg_node[seg]);
            for (int j = 1; j < 8; j++)
                dest_pool[j] = DEST_W'($urandom_range(0, NUM_DEST - 1));
            // Stall the output side for a long stretch while requests keep coming
            if (seg == 4)
                hold_go = 1'b1;
            start = n_requests;
            while (n_requests - start < SEG_ITEMS) begin
                if ($urandom_range(0, 99) < 60)
                    coord_round();
                else
                    random_request();
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d requests over %0d register settings, %0d result transfers",
                 n_requests, NUM_SEGS + 1, sb.checked);
        $display("including coordination rounds, broken rounds and a long output stall.");
        if (sb.errors == 0 && sb.outgoing_q.size() == 0)
            $display("distance_vector_route_coordinator_unit: match");
        else
            $display("distance_vector_route_coordinator_unit: mismatch");
        $finish;
    end

endmodule

[distance_vector_route_coordinator_unit.f]
sv/dvrc_pkg.sv
sv/dvrc_req_if.sv
sv/dvrc_msg_if.sv
sv/dvrc_ram.sv
sv/dvrc_engine.sv
sv/dvrc_ofifo.sv
sv/distance_vector_route_coordinator_unit.sv
tb/tb.sv
